// ===== rtl/srx_pkg.sv =====
// package for the serial frame receiver: status codes and field widths
// no dependencies; imported by serial_frame_receiver and tb_top
package srx_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HUNT    = 3'd0,
        ST_HEAD_OK = 3'd1,
        ST_LEN_OK  = 3'd2,
        ST_PAYLOAD = 3'd3,
        ST_GOOD    = 3'd4,
        ST_BAD     = 3'd5,
        ST_REJECT  = 3'd6
    } t_status;

    // register indexes on the configuration port
    localparam logic REG_HEAD_FIRST  = 1'b0;
    localparam logic REG_HEAD_SECOND = 1'b1;

endpackage

// ===== rtl/serial_frame_receiver.sv =====
// serial frame receiver: header hunt, length count, xor block check
// depends on srx_pkg
// a request passes the input register, then the result register, on its way to the result
// throughput: one byte per cycle while the result side does not stall; the frame state updates as a byte moves from
// the input register to the result register, in one pass of compare and xor logic
// a waiting result does not block the input register from taking one more byte
// reset (i_rst_n low, synchronous): both registers empty, hunting, headers zero
module serial_frame_receiver
    import srx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte input channel
    input  logic                i_data_valid,
    output logic                o_data_stall,
    input  logic [BYTE_W-1:0]   i_data_byte,
    // result channel
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [BYTE_W-1:0]   o_payload_out,
    output logic                o_frame_last,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_HEAD2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } t_phase;

    logic [BYTE_W-1:0]   r_head_first;
    logic [BYTE_W-1:0]   r_head_second;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;

    t_phase              r_phase,       n_phase;
    logic [BYTE_W-1:0]   r_bytes_left,  n_bytes_left;
    logic [BYTE_W-1:0]   r_running_xor, n_running_xor;

    logic                r_out_valid;
    t_status             r_out_status,  n_out_status;
    logic [BYTE_W-1:0]   r_out_payload, n_out_payload;
    logic                r_out_last,    n_out_last;

    logic                out_free;
    logic                advance;
    logic                cfg_write;
    logic [BYTE_W-1:0]   xor_next;

    // request flow between the two registers
    assign out_free     = ~r_out_valid | ~i_res_stall;
    assign advance      = r_in_valid & out_free;
    assign o_data_stall = r_in_valid & ~out_free;

    // configuration access
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_HEAD_FIRST:  prdata[BYTE_W-1:0] = r_head_first;
            REG_HEAD_SECOND: prdata[BYTE_W-1:0] = r_head_second;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= '0;
            r_head_second <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_HEAD_SECOND) begin
                r_head_second <= pwdata[BYTE_W-1:0];
            end else begin
                r_head_first <= pwdata[BYTE_W-1:0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_data_valid && !o_data_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data_valid && !o_data_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    // frame state and result for the byte in the input register
    assign xor_next = r_running_xor ^ r_in_byte;

    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_running_xor = r_running_xor;
        n_out_status  = ST_HUNT;
        n_out_payload = '0;
        n_out_last    = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == r_head_first) begin
                    n_phase      = PH_HEAD2;
                    n_bytes_left = BYTE_W'(1);
                    n_out_status = ST_HEAD_OK;
                end
            end
            PH_HEAD2: begin
                n_bytes_left = BYTE_W'(1);
                if (r_in_byte == r_head_second) begin
                    n_phase      = PH_LEN;
                    n_out_status = ST_HEAD_OK;
                end else begin
                    n_phase       = PH_HUNT;
                    n_running_xor = '0;
                    n_out_status  = ST_REJECT;
                end
            end
            PH_LEN: begin
                n_running_xor = '0;
                if (r_in_byte > BYTE_W'(1)) begin
                    n_phase      = PH_BODY;
                    n_bytes_left = r_in_byte;
                    n_out_status = ST_LEN_OK;
                end else begin
                    n_phase      = PH_HUNT;
                    n_bytes_left = BYTE_W'(1);
                    n_out_status = ST_REJECT;
                end
            end
            PH_BODY: begin
                if (r_bytes_left <= BYTE_W'(1)) begin
                    // check byte closes the frame
                    n_out_status  = (xor_next == '0) ? ST_GOOD : ST_BAD;
                    n_out_last    = 1'b1;
                    n_phase       = PH_HUNT;
                    n_bytes_left  = BYTE_W'(1);
                    n_running_xor = '0;
                end else begin
                    n_running_xor = xor_next;
                    n_bytes_left  = r_bytes_left - BYTE_W'(1);
                    n_out_status  = ST_PAYLOAD;
                    n_out_payload = r_in_byte;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // frame state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_bytes_left  <= BYTE_W'(1);
            r_running_xor <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (advance) begin
                r_phase       <= n_phase;
                r_bytes_left  <= n_bytes_left;
                r_running_xor <= n_running_xor;
                r_out_status  <= n_out_status;
                r_out_payload <= n_out_payload;
                r_out_last    <= n_out_last;
                r_out_valid   <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_payload_out = r_out_payload;
    assign o_frame_last  = r_out_last;

    // checks
    a_last_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == ((r_out_status == ST_GOOD) ||
                                        (r_out_status == ST_BAD))))
        else $error("frame_last disagrees with status");

    a_payload_only_on_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_PAYLOAD)) |-> (r_out_payload == '0))
        else $error("payload byte outside payload status");

    a_body_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_bytes_left != '0))
        else $error("byte counter empty in payload phase");

    a_hunt_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out_last) |=> (r_phase == PH_HUNT))
        else $error("no return to hunting after frame end");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_data_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room in the result register");

endmodule

// ===== bench/tb_top.sv =====
// testbench for serial_frame_receiver: frame hunting, length count and xor check
// depends on srx_pkg and serial_frame_receiver; self-checking, needs no other files
module tb_top;
    import srx_pkg::*;

    localparam int LATENCY        = 2;
    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 80;

    localparam logic [ADDR_W-1:0] ADDR_HEAD_FIRST  = {REG_HEAD_FIRST, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_HEAD_SECOND = {REG_HEAD_SECOND, 2'b00};

    // hunting phases of the frame tracker
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } t_hunt_phase;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] payload;
        logic              last;
    } t_frame_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_data_valid;
    logic                o_data_stall;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                o_res_valid;
    logic                i_res_stall;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_payload_out;
    logic                o_frame_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // frame tracker state and header registers as the block should hold them
    t_hunt_phase       hunt_phase = PH_FIRST;
    logic [BYTE_W-1:0] bytes_left = 8'd1;
    logic [BYTE_W-1:0] frame_xor = 8'd0;
    logic [BYTE_W-1:0] cfg_head_first = 8'd0;
    logic [BYTE_W-1:0] cfg_head_second = 8'd0;

    t_frame_result expected_results[$];

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  results_checked = 0;
    int  frames_good = 0;
    int  frames_bad = 0;
    int  rejects = 0;
    int  header_settings = 0;
    int  idle_cycles = 0;
    int  hold_off_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  stall_on = 1'b1;

    serial_frame_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_valid  (i_data_valid),
        .o_data_stall  (o_data_stall),
        .i_data_byte   (i_data_byte),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_status      (o_status),
        .o_payload_out (o_payload_out),
        .o_frame_last  (o_frame_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // back to hunting for the first header byte
    function automatic void restart_hunt();
        hunt_phase = PH_FIRST;
        bytes_left = 8'd1;
        frame_xor  = 8'd0;
    endfunction

    // expected result of one received byte; advances the tracker state
    function automatic t_frame_result predict_frame_status(input logic [BYTE_W-1:0] b);
        t_frame_result r;
        r.status  = ST_HUNT;
        r.payload = '0;
        r.last    = 1'b0;
        case (hunt_phase)
            PH_FIRST: begin
                if (b == cfg_head_first) begin
                    hunt_phase = PH_SECOND;
                    bytes_left = 8'd1;
                    r.status   = ST_HEAD_OK;
                end
            end
            PH_SECOND: begin
                // a wrong second header is dropped, not retried as a first header
                if (b == cfg_head_second) begin
                    hunt_phase = PH_LENGTH;
                    bytes_left = 8'd1;
                    r.status   = ST_HEAD_OK;
                end else begin
                    restart_hunt();
                    r.status = ST_REJECT;
                end
            end
            PH_LENGTH: begin
                if (b > 8'd1) begin
                    hunt_phase = PH_BODY;
                    bytes_left = b;
                    frame_xor  = 8'd0;
                    r.status   = ST_LEN_OK;
                end else begin
                    restart_hunt();
                    r.status = ST_REJECT;
                end
            end
            default: begin
                frame_xor = frame_xor ^ b;
                if (bytes_left <= 8'd1) begin
                    r.status = (frame_xor == 8'd0) ? ST_GOOD : ST_BAD;
                    r.last   = 1'b1;
                    restart_hunt();
                end else begin
                    bytes_left = bytes_left - 8'd1;
                    r.status   = ST_PAYLOAD;
                    r.payload  = b;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
        mismatches++;
    endtask

    // result checker and byte predictor, sampled at the rising edge
    always @(posedge i_clk) begin : result_monitor
        t_frame_result want;
        bit            moved;
        moved = 1'b0;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
                report_mismatch("status of an unexpected result", o_status, 8'd0);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_payload_out !== want.payload)
                    report_mismatch("payload_out", o_payload_out, want.payload);
                if (o_frame_last !== want.last)
                    report_mismatch("frame_last", o_frame_last, want.last);
                case (want.status)
                    ST_GOOD:   frames_good++;
                    ST_BAD:    frames_bad++;
                    ST_REJECT: rejects++;
                    default: ;
                endcase
            end
        end
        if (i_rst_n && i_data_valid && !o_data_stall) begin
            moved = 1'b1;
            expected_results.push_back(predict_frame_status(i_data_byte));
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // watchdog on handshake activity
    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL serial_frame_receiver");
        $finish;
    end

    // result side: random stall runs, plus a long hold-off on request
    initial begin : result_stall
        int     run_left;
        run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_res_stall = 1'b1;
                hold_off_cycles--;
            end else if (!stall_on) begin
                i_res_stall = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 9) < 7) begin
                i_res_stall = 1'b0;
                run_left = $urandom_range(1, 6);
            end else begin
                i_res_stall = 1'b1;
                run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 25)
                                                       : $urandom_range(0, 2);
            end
        end
    end

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one byte and hold it until the block takes it; entered and left at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_data_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_valid = 1'b1;
        i_data_byte  = value;
        @(posedge i_clk);
        while (o_data_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // full frame with the current headers; len_byte counts payload plus check byte
    task automatic send_frame(input logic [BYTE_W-1:0] len_byte, input bit bad_check);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = 8'd0;
        send_byte(cfg_head_first);
        send_byte(cfg_head_second);
        send_byte(len_byte);
        for (int i = 1; i < len_byte; i++) begin
            b = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            send_byte(b);
        end
        if (bad_check)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_for_idle();
        i_data_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {24'($urandom()), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_HEAD_FIRST)
            cfg_head_first = value;
        else
            cfg_head_second = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // header registers are only changed with the block drained
    task automatic write_header_regs(input logic [BYTE_W-1:0] first,
                                     input logic [BYTE_W-1:0] second);
        wait_for_idle();
        apb_write(ADDR_HEAD_FIRST, first);
        apb_write(ADDR_HEAD_SECOND, second);
        header_settings++;
    endtask

    // headers left at their reset value of zero
    task automatic test_reset_headers();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h5a);
        send_byte(8'h5a);
    endtask

    // hand-picked bytes: no header, rejected second header, short lengths, shortest frames
    task automatic test_directed();
        write_header_regs(8'hff, 8'h00);
        send_byte(8'h00);
        // wrong second header equal to the first header, then a byte that must not pass
        send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'h00);
        // length 0 and length 1
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h01);
        // one zero payload byte with a good check
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        // one payload byte with a bad check
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hff);
        send_byte(8'h7e);
    endtask

    // largest length byte
    task automatic test_longest_frame();
        write_header_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_frame(8'hff, 1'b0);
    endtask

    // result side held off while bytes keep coming, so the input stalls
    task automatic test_result_hold_off();
        write_header_regs(8'h3c, 8'hc3);
        gaps_on = 1'b0;
        @(posedge i_clk);
        hold_off_cycles = HOLD_OFF_LEN;
        @(negedge i_clk);
        repeat (3) send_frame(8'd8, 1'b0);
        gaps_on = 1'b1;
    endtask

    // mostly well-formed frames with random content, plus bad checks, broken headers, short lengths and noise
    task automatic test_random_traffic();
        logic [BYTE_W-1:0] hf;
        logic [BYTE_W-1:0] hs;
        int                start;
        int                r;
        for (int setting = 0; setting < 5; setting++) begin
            case (setting)
                0: begin hf = 8'h00; hs = 8'hff; end
                1: begin hf = 8'hff; hs = 8'hff; end
                2: begin hf = 8'h00; hs = 8'h00; end
                default: begin
                    hf = 8'($urandom_range(0, 255));
                    hs = 8'($urandom_range(0, 255));
                end
            endcase
            write_header_regs(hf, hs);
            // one setting runs back to back with no idling on either side
            gaps_on  = (setting != 2);
            stall_on = (setting != 2);
            start = bytes_sent;
            while (bytes_sent - start < RANDOM_ITEMS / 5) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    send_frame(($urandom_range(0, 19) == 0) ? 8'($urandom_range(13, 255))
                                                            : 8'($urandom_range(2, 12)), 1'b0);
                end else if (r < 75) begin
                    send_frame(8'($urandom_range(2, 12)), 1'b1);
                end else if (r < 83) begin
                    send_byte(hf);
                    send_byte(hs ^ 8'($urandom_range(1, 255)));
                end else if (r < 90) begin
                    send_byte(hf);
                    send_byte(hs);
                    send_byte(8'($urandom_range(0, 1)));
                end else begin
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_data_valid = 1'b0;
        i_data_byte  = '0;
        i_res_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_headers();
        test_directed();
        test_longest_frame();
        test_result_hold_off();
        test_random_traffic();

        wait_for_idle();
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("sent %0d bytes under %0d header settings, checked %0d results",
                 bytes_sent, header_settings + 1, results_checked);
        $display("frames good %0d, check failed %0d, rejected %0d, mismatches %0d",
                 frames_good, frames_bad, rejects, mismatches);
        if (mismatches == 0)
            $display("PASS serial_frame_receiver");
        else
            $display("FAIL serial_frame_receiver");
        $finish;
    end

endmodule
